>>> sv/ratree_pkg.sv
`timescale 1ns / 1ps
// ratree_pkg: shared constants and the controller-to-datapath command word
// for range_add_argmin_tree. No dependencies.
package ratree_pkg;
  localparam int POS_W          = 10;   // leaf_position, range bounds, min_position
  localparam int VAL_W          = 48;   // operand_value, min_value
  localparam int CNT_W          = 11;   // active_count register
  localparam int DEF_LEAVES     = 1024;
  localparam int DEF_VALUE_BITS = 48;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic clear;     // write zero at addr (reset sweep)
    logic take;      // latch the accepted word
    logic first;     // first read of a sweep, restart the minimum search
    logic rd;        // read leaf at addr
    logic out_load;  // copy the finished minimum to the output registers
  } ratree_cmd_t;
endpackage

>>> sv/ratree_ctrl.sv
`timescale 1ns / 1ps
// ratree_ctrl: sequencer for the reset clearing pass and the per-word leaf sweep.
// Depends on ratree_pkg.
module ratree_ctrl #(
  parameter int LEAVES = ratree_pkg::DEF_LEAVES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ratree_pkg::ratree_cmd_t   cmd,
  output logic [$clog2(LEAVES)-1:0] addr
);
  import ratree_pkg::*;

  localparam int AW = $clog2(LEAVES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SWEEP, S_LAST, S_FIN} state_t;

  state_t        state;
  logic [AW-1:0] cnt;
  logic          cnt_end;

  assign cnt_end  = (cnt == AW'(LEAVES - 1));
  assign addr     = cnt;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.take     = (state == S_IDLE) && in_valid;
    cmd.rd       = (state == S_SWEEP);
    cmd.first    = (state == S_SWEEP) && (cnt == '0);
    cmd.out_load = (state == S_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= S_LAST;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LAST: state <= S_FIN;  // last leaf leaves the read stage
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/ratree_dp.sv
`timescale 1ns / 1ps
// ratree_dp: leaf memory, saturating update and running minimum search.
// Depends on ratree_pkg; driven by ratree_ctrl.
module ratree_dp #(
  parameter int LEAVES     = ratree_pkg::DEF_LEAVES,
  parameter int VALUE_BITS = ratree_pkg::DEF_VALUE_BITS
) (
  input  logic                                    clk,
  input  ratree_pkg::ratree_cmd_t                 cmd,
  input  logic [$clog2(LEAVES)-1:0]               addr,
  input  logic [ratree_pkg::CNT_W-1:0]            active_count,
  input  logic                                    op,
  input  logic [ratree_pkg::POS_W-1:0]            leaf_position,
  input  logic [ratree_pkg::POS_W-1:0]            range_low,
  input  logic [ratree_pkg::POS_W-1:0]            range_high,
  input  logic signed [ratree_pkg::VAL_W-1:0]     operand_value,
  output logic signed [ratree_pkg::VAL_W-1:0]     min_value,
  output logic [ratree_pkg::POS_W-1:0]            min_position,
  output logic                                    range_was_empty
);
  import ratree_pkg::*;

  localparam int AW = $clog2(LEAVES);
  localparam int PW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int EW = ((VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W) + 2;
  localparam int VB = VALUE_BITS;

  logic [VB-1:0] leaf_mem [LEAVES];
  logic [VB-1:0] rdata;

  // latched word
  logic                    op_q;
  logic [POS_W-1:0]        pos_q, lo_q, hi_q;
  logic signed [VAL_W-1:0] opv_q;

  logic          s1;
  logic [AW-1:0] idx1;

  logic          best_valid;
  logic [VB-1:0] best_val;
  logic [AW-1:0] best_pos;

  logic [PW-1:0]        idx_x, pos_x, lo_x, hi_x, act_x;
  logic signed [EW-1:0] opx, leafx, cand, vmax_x, vmin_x, clamped;
  logic                 empty, modify, active, better;
  logic [VB-1:0]        newv, wval;
  logic [EW-1:0]        best_x;
  logic [PW-1:0]        bpos_x;

  always_comb begin
    idx_x   = PW'(idx1);
    pos_x   = PW'(pos_q);
    lo_x    = PW'(lo_q);
    hi_x    = PW'(hi_q);
    act_x   = PW'(active_count);
    empty   = (op_q == OP_ADD) && (lo_q > hi_q);
    modify  = (op_q == OP_LOAD) ? (pos_x == idx_x)
                                : (!empty && lo_x <= idx_x && idx_x <= hi_x);
    opx     = {{(EW-VAL_W){opv_q[VAL_W-1]}}, opv_q};
    leafx   = {{(EW-VB){rdata[VB-1]}}, rdata};
    vmax_x  = {{(EW-VB+1){1'b0}}, {(VB-1){1'b1}}};
    vmin_x  = ~vmax_x;
    cand    = (op_q == OP_ADD) ? (leafx + opx) : opx;
    clamped = (cand > vmax_x) ? vmax_x : ((cand < vmin_x) ? vmin_x : cand);
    newv    = clamped[VB-1:0];
    wval    = modify ? newv : rdata;
    // count 0 acts as 1: position zero is always in use
    active  = (idx1 == '0) || (idx_x < act_x);
    // ascending scan, so <= hands ties to the larger position
    better  = active && (!best_valid || $signed(wval) <= $signed(best_val));
    best_x  = {{(EW-VB){best_val[VB-1]}}, best_val};
    bpos_x  = PW'(best_pos);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) leaf_mem[addr] <= '0;
    if (cmd.rd) rdata <= leaf_mem[addr];
    if (s1 && modify) leaf_mem[idx1] <= newv;
  end

  always_ff @(posedge clk) begin
    s1   <= cmd.rd;
    idx1 <= addr;
    if (cmd.take) begin
      op_q  <= op;
      pos_q <= leaf_position;
      lo_q  <= range_low;
      hi_q  <= range_high;
      opv_q <= operand_value;
    end
    if (cmd.first) best_valid <= 1'b0;
    else if (s1 && better) begin
      best_valid <= 1'b1;
      best_val   <= wval;
      best_pos   <= idx1;
    end
    if (cmd.out_load) begin
      min_value       <= best_x[VAL_W-1:0];
      min_position    <= bpos_x[POS_W-1:0];
      range_was_empty <= empty;
    end
  end
endmodule

>>> sv/range_add_argmin_tree.sv
`timescale 1ns / 1ps
// range_add_argmin_tree: top level, active_count register plus controller and datapath.
// Depends on ratree_pkg, ratree_ctrl, ratree_dp.
//
// Keeps LEAVES signed leaf values in one memory with one read and one write
// per cycle. Each input word either loads one leaf (op 0) or adds operand_value
// to every leaf in [range_low, range_high] (op 1), saturating leaf by leaf at
// the VALUE_BITS limits; low above high changes nothing and sets
// range_was_empty. After each word one result gives the minimum over positions
// below active_count (position zero always counts) and its position, the
// larger position on ties. Every word is one full sweep of the leaf memory, one
// leaf per cycle (read, update and write back, compare); the minimum is then
// copied into the output registers, and only then is a new word taken. One
// word is in work at a time; a finished result waits in the output register
// while the next word is accepted. After reset a clearing pass over all LEAVES
// leaves zeroes the memory, with in_ready low; active_count may be written at
// any time the block is idle, including during that pass.
module range_add_argmin_tree #(
  parameter int LEAVES     = ratree_pkg::DEF_LEAVES,
  parameter int VALUE_BITS = ratree_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [ratree_pkg::POS_W-1:0]        leaf_position,
  input  logic [ratree_pkg::POS_W-1:0]        range_low,
  input  logic [ratree_pkg::POS_W-1:0]        range_high,
  input  logic signed [ratree_pkg::VAL_W-1:0] operand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ratree_pkg::VAL_W-1:0] min_value,
  output logic [ratree_pkg::POS_W-1:0]        min_position,
  output logic                                range_was_empty,
  input  logic                                cfg_we,
  input  logic [ratree_pkg::CNT_W-1:0]        cfg_wdata
);
  import ratree_pkg::*;

  localparam int AW = $clog2(LEAVES);

  logic [CNT_W-1:0] active_count;
  ratree_cmd_t      cmd;
  logic [AW-1:0]    addr;

  // active_count resets to all leaves of a full-size block
  always_ff @(posedge clk) begin
    if (rst) active_count <= CNT_W'(1024);
    else if (cfg_we) active_count <= cfg_wdata;
  end

  ratree_ctrl #(.LEAVES(LEAVES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .addr     (addr)
  );

  ratree_dp #(.LEAVES(LEAVES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .addr           (addr),
    .active_count   (active_count),
    .op             (op),
    .leaf_position  (leaf_position),
    .range_low      (range_low),
    .range_high     (range_high),
    .operand_value  (operand_value),
    .min_value      (min_value),
    .min_position   (min_position),
    .range_was_empty(range_was_empty)
  );
endmodule
